@@ hdl/otsu_pkg.sv @@
package otsu_pkg;

  // Histogram geometry
  localparam int BIN_SLOTS = 256;
  localparam int BIN_W     = 8;

  // Frame statistics widths
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 24;
  localparam int PROD_W = CNT_W + SUM_W;
  localparam int DEN_W  = 2 * CNT_W;

  // Multi-cycle multiplier: one 16-bit digit of A per cycle, MSB digit first
  localparam int SQ_W       = 2 * PROD_W;
  localparam int MUL_B_W    = PROD_W;
  localparam int MUL_P_W    = SQ_W + MUL_B_W;
  localparam int DIG_W      = 16;
  localparam int MUL_DIGITS = SQ_W / DIG_W;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // Defaults for the top-level parameters
  localparam int DEF_MAX_PIXELS  = 32768;
  localparam int DEF_GRAY_LEVELS = 256;

  // Histogram memory command: pixel increment and scan/clear sweep
  typedef struct packed {
    logic             upd;
    logic [BIN_W-1:0] upd_bin;
    logic             sweep;
    logic [BIN_W-1:0] sweep_addr;
  } hist_cmd_t;

endpackage

@@ hdl/otsu_if.sv @@
interface otsu_px_if;
  import otsu_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] pixel;
  logic             last;
  modport source (output valid, output pixel, output last, input ready);
  modport sink   (input valid, input pixel, input last, output ready);
endinterface

interface otsu_res_if;
  import otsu_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] threshold;
  logic             overflow;
  modport source (output valid, output threshold, output overflow, input ready);
  modport sink   (input valid, input threshold, input overflow, output ready);
endinterface

@@ hdl/otsu_hist.sv @@
module otsu_hist import otsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hist_cmd_t        cmd,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] hist_mem [BIN_SLOTS];
  logic [CNT_W-1:0] rd_data_r;

  logic             s1_v_r;
  logic [BIN_W-1:0] s1_bin_r;
  logic             w_v_r;
  logic [BIN_W-1:0] w_bin_r;
  logic [CNT_W-1:0] w_data_r;

  logic [BIN_W-1:0] rd_addr;
  logic [BIN_W-1:0] wr_addr;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] wr_data;
  logic             wr_en;

  assign rd_addr = cmd.sweep ? cmd.sweep_addr : cmd.upd_bin;

  // Forward the write of the previous cycle when the same bin comes back
  assign cur_cnt = (w_v_r && (w_bin_r == s1_bin_r)) ? w_data_r : rd_data_r;
  assign wr_en   = s1_v_r | cmd.sweep;
  assign wr_addr = s1_v_r ? s1_bin_r : cmd.sweep_addr;
  assign wr_data = s1_v_r ? cur_cnt + CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    rd_data_r <= hist_mem[rd_addr];
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      w_v_r  <= 1'b0;
    end else begin
      s1_v_r <= cmd.upd;
      w_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_bin_r <= cmd.upd_bin;
    w_bin_r  <= s1_bin_r;
    w_data_r <= wr_data;
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/otsu_mul.sv @@
module otsu_mul import otsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SQ_W-1:0]    a,
  input  logic [MUL_B_W-1:0] b,
  output logic               busy,
  output logic               done,
  output logic [MUL_P_W-1:0] p
);

  logic [SQ_W-1:0]          a_r;
  logic [MUL_B_W-1:0]       b_r;
  logic [MUL_P_W-1:0]       acc_r;
  logic [MUL_CNT_W-1:0]     cnt_r;
  logic                     busy_r;
  logic                     done_r;
  logic [DIG_W+MUL_B_W-1:0] part;
  logic [MUL_P_W-1:0]       acc_nxt;

  assign part    = a_r[SQ_W-1 -: DIG_W] * b_r;
  assign acc_nxt = {acc_r[MUL_P_W-DIG_W-1:0], DIG_W'(0)} + MUL_P_W'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_DIGITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MUL_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[SQ_W-DIG_W-1:0], DIG_W'(0)};
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = acc_r;

endmodule

@@ hdl/otsu_threshold_finder.sv @@
// Otsu threshold finder for 8-bit gray frames. Pixels stream in one per cycle
// on in_px while ready is high and are counted into a 256-bin histogram held
// in a single-port-write RAM (read-modify-write with forwarding of the
// previous write), while the pixel count and gray sum are kept in registers.
// A transfer with last set closes the frame: the block drops ready and scans
// the bins, keeping cumulative count n0 and sum s0, and picks the first bin
// that strictly maximizes (N*s0 - S*n0)^2 / (n0*(N-n0)), compared exactly by
// cross-multiplication; bins with n0 of 0 or N are skipped. A skipped bin
// passes through S_RD, S_ACC and S_AB; a scored bin goes on through S_D,
// S_SQ, S_LHS and S_RHS, paced by the shared multi-cycle multiplier (5 digit
// steps per product, three products per bin). When the scan ends, the result
// is offered on out_res. Bins are zeroed as they are scanned. After reset a
// clearing pass zeroes all 256 bins before the first pixel is taken. Once
// MAX_PIXELS pixels are counted, further pixels of the frame are dropped and
// overflow is reported with the threshold; 0 is reported when no bin scores.
module otsu_threshold_finder import otsu_pkg::*; #(
  parameter int MAX_PIXELS  = DEF_MAX_PIXELS,
  parameter int GRAY_LEVELS = DEF_GRAY_LEVELS
) (
  input  logic       clk,
  input  logic       rst_n,
  otsu_px_if.sink    in_px,
  otsu_res_if.source out_res
);

  localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(GRAY_LEVELS - 1);
  localparam logic [BIN_W-1:0] LAST_SLOT = BIN_W'(BIN_SLOTS - 1);
  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PIXELS);

  typedef enum logic [9:0] {
    S_CLR   = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_DRAIN = 10'b00_0000_0100,
    S_RD    = 10'b00_0000_1000,
    S_ACC   = 10'b00_0001_0000,
    S_AB    = 10'b00_0010_0000,
    S_D     = 10'b00_0100_0000,
    S_SQ    = 10'b00_1000_0000,
    S_LHS   = 10'b01_0000_0000,
    S_RHS   = 10'b10_0000_0000
  } state_t;

  // S_DONE is folded into a flag so the enum stays one code per state above
  state_t           state_r, state_nxt;
  logic             fin_r, fin_nxt;

  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [SUM_W-1:0] gsum_r, gsum_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] n0_r, n0_nxt;
  logic [SUM_W-1:0] s0_r, s0_nxt;
  logic [SQ_W-1:0]  best_sq_r, best_sq_nxt;
  logic [DEN_W-1:0] best_den_r, best_den_nxt;
  logic [BIN_W-1:0] best_r, best_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0] out_thr_r;
  logic             out_ovf_r;

  logic [PROD_W-1:0]  a_r, b_r;
  logic [DEN_W-1:0]   den_r;
  logic [SQ_W-1:0]    sq_r;
  logic [MUL_P_W-1:0] lhs_r;

  logic             in_acc;
  logic             counting;
  logic [BIN_W-1:0] px_clamp;
  logic [CNT_W-1:0] hist_rd;
  logic [SUM_W-1:0] bin_mass;
  logic [PROD_W-1:0] diff;
  logic             skip;
  logic             load_out;
  hist_cmd_t        hcmd;

  logic               mul_start;
  logic [SQ_W-1:0]    mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_busy;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;

  // Input side: take pixels only between frames' scans
  assign in_px.ready = (state_r == S_IDLE) && !fin_r;
  assign in_acc      = in_px.valid && in_px.ready;
  assign px_clamp    = (in_px.pixel > LAST_BIN) ? LAST_BIN : in_px.pixel;
  assign counting    = in_acc && (total_r < MAX_CNT);

  // Sweep reads a bin for the scan and zeroes it in the same cycle
  assign hcmd.upd        = counting;
  assign hcmd.upd_bin    = px_clamp;
  assign hcmd.sweep      = (state_r == S_CLR) || (state_r == S_RD);
  assign hcmd.sweep_addr = bin_r;

  otsu_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (hcmd),
    .rd_data (hist_rd)
  );

  assign bin_mass = SUM_W'(hist_rd) * SUM_W'(bin_r);
  assign diff     = (a_r > b_r) ? a_r - b_r : b_r - a_r;
  assign skip     = (n0_r == '0) || (n0_r >= total_r);

  // Multiplier sequence per scored bin: d*d, then d^2*best_den, then
  // best_d^2*den
  always_comb begin
    mul_a = best_sq_r;
    mul_b = MUL_B_W'(den_r);
    case (state_r)
      S_D: begin
        mul_a = SQ_W'(diff);
        mul_b = diff;
      end
      S_SQ: begin
        mul_a = mul_p[SQ_W-1:0];
        mul_b = MUL_B_W'(best_den_r);
      end
      default: begin
        mul_a = best_sq_r;
        mul_b = MUL_B_W'(den_r);
      end
    endcase
  end

  assign mul_start = (state_r == S_D) ||
                     (((state_r == S_SQ) || (state_r == S_LHS)) && mul_done);

  otsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign load_out = fin_r && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt     = state_r;
    fin_nxt       = fin_r;
    bin_nxt       = bin_r;
    total_nxt     = total_r;
    gsum_nxt      = gsum_r;
    ovf_nxt       = ovf_r;
    n0_nxt        = n0_r;
    s0_nxt        = s0_r;
    best_sq_nxt   = best_sq_r;
    best_den_nxt  = best_den_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_res.ready;

    case (state_r)
      S_CLR: begin
        bin_nxt = bin_r + BIN_W'(1);
        if (bin_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (load_out) begin
          // Hand over the result and open the next frame
          out_valid_nxt = 1'b1;
          fin_nxt       = 1'b0;
          total_nxt     = '0;
          gsum_nxt      = '0;
          ovf_nxt       = 1'b0;
        end else if (in_acc) begin
          if (counting) begin
            total_nxt = total_r + CNT_W'(1);
            gsum_nxt  = gsum_r + SUM_W'(px_clamp);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_px.last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // Let the last increment land before the scan reads bin 0
        bin_nxt      = '0;
        n0_nxt       = '0;
        s0_nxt       = '0;
        best_sq_nxt  = '0;
        best_den_nxt = DEN_W'(1);
        best_nxt     = '0;
        state_nxt    = S_RD;
      end
      S_RD: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        n0_nxt    = n0_r + hist_rd;
        s0_nxt    = s0_r + bin_mass;
        state_nxt = S_AB;
      end
      S_AB: begin
        if (skip) begin
          if (bin_r == LAST_BIN) begin
            state_nxt = S_IDLE;
            fin_nxt   = 1'b1;
          end else begin
            bin_nxt   = bin_r + BIN_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          state_nxt = S_D;
        end
      end
      S_D: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (mul_done) begin
          state_nxt = S_LHS;
        end
      end
      S_LHS: begin
        if (mul_done) begin
          state_nxt = S_RHS;
        end
      end
      S_RHS: begin
        if (mul_done) begin
          if (lhs_r > mul_p) begin
            best_sq_nxt  = sq_r;
            best_den_nxt = den_r;
            best_nxt     = bin_r;
          end
          if (bin_r == LAST_BIN) begin
            state_nxt = S_IDLE;
            fin_nxt   = 1'b1;
          end else begin
            bin_nxt   = bin_r + BIN_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fin_r       <= 1'b0;
      bin_r       <= '0;
      total_r     <= '0;
      gsum_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      bin_r       <= bin_nxt;
      total_r     <= total_nxt;
      gsum_r      <= gsum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan datapath: products are registered before the next use
  always_ff @(posedge clk) begin
    n0_r       <= n0_nxt;
    s0_r       <= s0_nxt;
    best_sq_r  <= best_sq_nxt;
    best_den_r <= best_den_nxt;
    best_r     <= best_nxt;
    if (state_r == S_AB) begin
      a_r   <= PROD_W'(total_r) * PROD_W'(s0_r);
      b_r   <= PROD_W'(gsum_r) * PROD_W'(n0_r);
      den_r <= DEN_W'(n0_r) * DEN_W'(total_r - n0_r);
    end
    if ((state_r == S_SQ) && mul_done) begin
      sq_r <= mul_p[SQ_W-1:0];
    end
    if ((state_r == S_LHS) && mul_done) begin
      lhs_r <= mul_p;
    end
    if (load_out) begin
      out_thr_r <= best_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.threshold = out_thr_r;
  assign out_res.overflow  = out_ovf_r;

`ifndef ASSERT_OFF
  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_CNT)
    else $error("pixel count passed the frame limit");

  a_scan_sums_all: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> (n0_r == total_r))
    else $error("scan did not account for every counted pixel");

  a_mul_idle_on_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_px.ready |-> !mul_busy)
    else $error("multiplier busy while pixels are taken");

  a_best_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RHS) |-> (best_den_r != '0))
    else $error("best denominator is zero during comparison");
`endif

endmodule
